>>> design/dctp_pkg.sv
// Shared types, constants and helpers for the display command text parser.
// Used by the front classifier, the token queue and the back-end executor.
package dctp_pkg;

  // Width of the register value accumulator and of the reported value
  localparam int ValueBits = 16;

  // Token queue between front and back
  localparam int QueueDepth = 4;
  localparam int QueuePtrBits = $clog2(QueueDepth);
  localparam int QueueCntBits = $clog2(QueueDepth + 1);

  // Character codes
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChQuote = 8'h27;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoZ   = 8'h7A;
  localparam logic [7:0] CaseGap = 8'h20;

  // G codes that switch the coordinate mode
  localparam logic [ValueBits-1:0] GAbsolute = ValueBits'(90);
  localparam logic [ValueBits-1:0] GRelative = ValueBits'(91);

  localparam logic [15:0] Sat16 = 16'hFFFF;

  // Register index of G
  localparam logic [3:0] RegG = 4'd0;

  // Token classes produced by the front end
  typedef enum logic [2:0] {
    TOK_SKIP,
    TOK_QUOTE,
    TOK_NEWLINE,
    TOK_MINUS,
    TOK_DIGIT,
    TOK_LETTER,
    TOK_BAD_LETTER,
    TOK_OTHER
  } tok_class_t;

  typedef struct packed {
    logic       eot;
    tok_class_t cls;
    logic [3:0] reg_index;
    logic       upper;
    logic [3:0] digit;
  } token_t;

  // Result event kinds
  typedef enum logic [2:0] {
    EV_WRITE   = 3'd0,
    EV_EXECUTE = 3'd1,
    EV_STRING  = 3'd2,
    EV_ERROR   = 3'd3,
    EV_DONE    = 3'd4
  } ev_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_EXPECT_REG = 2'd1,
    ERR_BAD_REG    = 2'd2
  } err_code_t;

  typedef struct packed {
    ev_kind_t              kind;
    logic [3:0]            reg_index;
    logic [ValueBits-1:0]  value;
    logic                  code_known;
    logic                  relative_mode;
    logic [15:0]           line_number;
    logic [15:0]           char_position;
    logic [15:0]           string_start;
    logic [15:0]           string_length;
    err_code_t             error_code;
  } event_t;

  // Saturating 16-bit increment
  function automatic logic [15:0] sat_inc(input logic [15:0] x);
    return (x == Sat16) ? x : x + 16'd1;
  endfunction

  // G codes the display knows how to run
  function automatic logic code_known(input logic [ValueBits-1:0] g);
    return (g == ValueBits'(0)) || (g == ValueBits'(1)) || (g == ValueBits'(2)) ||
           (g == ValueBits'(4)) || (g == ValueBits'(5)) || (g == ValueBits'(6)) ||
           (g == ValueBits'(7)) || (g == ValueBits'(8)) || (g == ValueBits'(50));
  endfunction

  // Upper-case register letter to index; valid low when not a register
  function automatic logic [4:0] reg_lookup(input logic [7:0] up);
    logic [4:0] r;
    r = 5'd0;
    case (up)
      "G": r = {1'b1, 4'd0};
      "D": r = {1'b1, 4'd1};
      "S": r = {1'b1, 4'd2};
      "F": r = {1'b1, 4'd3};
      "X": r = {1'b1, 4'd4};
      "Y": r = {1'b1, 4'd5};
      "W": r = {1'b1, 4'd6};
      "H": r = {1'b1, 4'd7};
      "U": r = {1'b1, 4'd8};
      "P": r = {1'b1, 4'd9};
      "R": r = {1'b1, 4'd10};
      "T": r = {1'b1, 4'd11};
      "C": r = {1'b1, 4'd12};
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

>>> design/display_command_text_parser_unit.sv
// Top level of the display command text parser.
// Instantiates dctp_front, dctp_queue and dctp_back; types from dctp_pkg.
//
// Usage:
//   Character channel: char_valid / char_stall with char_code and
//   end_of_text. One transaction carries one byte of page text, or the
//   end-of-text marker that finishes the page.
//   Event channel: event_valid / event_stall with kind, reg_index, value,
//   code_known, relative_mode, line_number, char_position, string_start,
//   string_length, error_code and last. Each character yields zero to three
//   events; last marks the final event of a character.
//   Tokens pass the token queue and events leave through the event register.
//   The front takes one character per cycle into a four-entry token queue;
//   the back retires one token per cycle, or one event per cycle when a
//   token yields several, so unstalled throughput is one character per
//   cycle except where characters produce multiple events.
//   When the receiver stalls, the event register holds its transaction,
//   the queue fills and char_stall rises once four tokens are waiting.
//   Reset (rst, synchronous) empties the queue, drops event_valid and
//   returns the parser to the start of a page. End of text also returns
//   the parser to that state after its done event.
module display_command_text_parser_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_stall,
  input  logic [7:0]         char_code,
  input  logic               end_of_text,
  output logic               event_valid,
  input  logic               event_stall,
  output logic [2:0]         kind,
  output logic [3:0]         reg_index,
  output logic signed [15:0] value,
  output logic               code_known,
  output logic               relative_mode,
  output logic [15:0]        line_number,
  output logic [15:0]        char_position,
  output logic [15:0]        string_start,
  output logic [15:0]        string_length,
  output logic [1:0]         error_code,
  output logic               last
);

  logic              push;
  dctp_pkg::token_t  push_token;
  logic              queue_full;
  logic              pop;
  logic              head_valid;
  dctp_pkg::token_t  head_token;
  dctp_pkg::event_t  event_data;

  // Classifier
  dctp_front u_front (
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_code  (char_code),
    .end_of_text(end_of_text),
    .queue_full (queue_full),
    .push       (push),
    .push_token (push_token)
  );

  // Token queue
  dctp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_token(push_token),
    .full      (queue_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_token(head_token)
  );

  // Executor
  dctp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_token (head_token),
    .pop        (pop),
    .event_valid(event_valid),
    .event_stall(event_stall),
    .event_data (event_data),
    .event_last (last)
  );

  // Event fields to ports
  assign kind          = event_data.kind;
  assign reg_index     = event_data.reg_index;
  assign value         = 16'(event_data.value);
  assign code_known    = event_data.code_known;
  assign relative_mode = event_data.relative_mode;
  assign line_number   = event_data.line_number;
  assign char_position = event_data.char_position;
  assign string_start  = event_data.string_start;
  assign string_length = event_data.string_length;
  assign error_code    = event_data.error_code;

endmodule

>>> design/dctp_front.sv
// Front end: takes characters in and classifies each into a token for the queue.
// Depends on dctp_pkg.
module dctp_front (
  input  logic              char_valid,
  output logic              char_stall,
  input  logic [7:0]        char_code,
  input  logic              end_of_text,
  input  logic              queue_full,
  output logic              push,
  output dctp_pkg::token_t  push_token
);

  logic       is_upper;
  logic       is_lower;
  logic [7:0] folded;
  logic [4:0] lookup;

  // Accept whenever the queue has room
  assign char_stall = queue_full;
  assign push       = char_valid && !queue_full;

  // Letter folding and register lookup
  assign is_upper = (char_code >= dctp_pkg::ChUpA) && (char_code <= dctp_pkg::ChUpZ);
  assign is_lower = (char_code >= dctp_pkg::ChLoA) && (char_code <= dctp_pkg::ChLoZ);
  assign folded   = is_lower ? (char_code - dctp_pkg::CaseGap) : char_code;
  assign lookup   = dctp_pkg::reg_lookup(folded);

  // Token classification
  always_comb begin
    push_token.eot       = end_of_text;
    push_token.reg_index = lookup[3:0];
    push_token.upper     = is_upper;
    push_token.digit     = 4'(char_code - dctp_pkg::ChZero);
    if (char_code == dctp_pkg::ChSpace || char_code == dctp_pkg::ChCr) begin
      push_token.cls = dctp_pkg::TOK_SKIP;
    end else if (char_code == dctp_pkg::ChQuote) begin
      push_token.cls = dctp_pkg::TOK_QUOTE;
    end else if (char_code == dctp_pkg::ChLf) begin
      push_token.cls = dctp_pkg::TOK_NEWLINE;
    end else if (char_code == dctp_pkg::ChMinus) begin
      push_token.cls = dctp_pkg::TOK_MINUS;
    end else if (char_code >= dctp_pkg::ChZero && char_code <= dctp_pkg::ChNine) begin
      push_token.cls = dctp_pkg::TOK_DIGIT;
    end else if (is_upper || is_lower) begin
      push_token.cls = lookup[4] ? dctp_pkg::TOK_LETTER : dctp_pkg::TOK_BAD_LETTER;
    end else begin
      push_token.cls = dctp_pkg::TOK_OTHER;
    end
  end

endmodule

>>> design/dctp_queue.sv
// Short token queue that decouples the front classifier from the back executor.
// Depends on dctp_pkg.
module dctp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dctp_pkg::token_t  push_token,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output dctp_pkg::token_t  head_token
);

  dctp_pkg::token_t                    entries [dctp_pkg::QueueDepth];
  logic [dctp_pkg::QueuePtrBits-1:0]   wptr;
  logic [dctp_pkg::QueuePtrBits-1:0]   rptr;
  logic [dctp_pkg::QueueCntBits-1:0]   count;

  assign full       = (count == dctp_pkg::QueueCntBits'(dctp_pkg::QueueDepth));
  assign head_valid = (count != '0);
  assign head_token = entries[rptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + dctp_pkg::QueuePtrBits'(1);
      end
      if (pop) begin
        rptr <= rptr + dctp_pkg::QueuePtrBits'(1);
      end
      if (push && !pop) begin
        count <= count + dctp_pkg::QueueCntBits'(1);
      end else if (pop && !push) begin
        count <= count - dctp_pkg::QueueCntBits'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_token;
    end
  end

endmodule

>>> design/dctp_back.sv
// Back end: runs the parse state on queued tokens and emits result events.
// Depends on dctp_pkg; holds the output register of the event channel.
module dctp_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            head_valid,
  input  dctp_pkg::token_t                head_token,
  output logic                            pop,
  output logic                            event_valid,
  input  logic                            event_stall,
  output dctp_pkg::event_t                event_data,
  output logic                            event_last
);

  typedef enum logic [1:0] {
    MODE_EXPECT,
    MODE_VALUE,
    MODE_DIGITS,
    MODE_STRING
  } mode_t;

  localparam int VB = dctp_pkg::ValueBits;

  // Parse state
  mode_t                 mode, mode_next;
  logic [3:0]            preg, preg_next;
  logic                  pupper, pupper_next;
  logic                  neg, neg_next;
  logic [VB-1:0]         acc, acc_next;
  logic [VB-1:0]         opc, opc_next;
  logic                  rel, rel_next;
  logic                  has_writes, has_writes_next;
  logic [15:0]           line_cnt, line_cnt_next;
  logic [15:0]           pos_cnt, pos_cnt_next;
  logic [15:0]           byte_off, byte_off_next;
  logic [15:0]           str_begin, str_begin_next;
  logic [15:0]           str_count, str_count_next;
  dctp_pkg::err_code_t   err, err_next;

  // Event sequencing
  dctp_pkg::event_t      ev [3];
  logic [1:0]            ev_count;
  logic [1:0]            idx;
  logic                  out_ready;
  logic                  last_ev;
  logic                  tok_go;
  logic                  nl_go;
  logic [VB-1:0]         wv;

  function automatic dctp_pkg::event_t mk_event(
    input dctp_pkg::ev_kind_t  kind,
    input logic [3:0]          ri,
    input logic [VB-1:0]       val,
    input logic                known,
    input logic                r,
    input logic [15:0]         lc,
    input logic [15:0]         pc,
    input logic [15:0]         ss,
    input logic [15:0]         sl,
    input dctp_pkg::err_code_t ec
  );
    dctp_pkg::event_t e;
    e.kind          = kind;
    e.reg_index     = ri;
    e.value         = val;
    e.code_known    = known;
    e.relative_mode = r;
    e.line_number   = lc;
    e.char_position = pc;
    e.string_start  = ss;
    e.string_length = sl;
    e.error_code    = ec;
    return e;
  endfunction

  // Pending write value with sign applied
  assign wv = neg ? (VB'(0) - acc) : acc;

  // Events and next state for the token at the queue head
  always_comb begin
    mode_next       = mode;
    preg_next       = preg;
    pupper_next     = pupper;
    neg_next        = neg;
    acc_next        = acc;
    opc_next        = opc;
    rel_next        = rel;
    has_writes_next = has_writes;
    line_cnt_next   = line_cnt;
    pos_cnt_next    = pos_cnt;
    byte_off_next   = byte_off;
    str_begin_next  = str_begin;
    str_count_next  = str_count;
    err_next        = err;
    ev[0]           = '0;
    ev[1]           = '0;
    ev[2]           = '0;
    ev_count        = 2'd0;
    tok_go          = 1'b0;
    nl_go           = 1'b0;

    if (head_token.eot) begin
      // End of text: flush pending work, run last line, report done
      if (err == dctp_pkg::ERR_NONE) begin
        if (mode == MODE_VALUE || mode == MODE_DIGITS) begin
          if (preg == dctp_pkg::RegG) begin
            opc_next = wv;
            if (pupper && wv == dctp_pkg::GAbsolute) begin
              rel_next = 1'b0;
            end else if (pupper && wv == dctp_pkg::GRelative) begin
              rel_next = 1'b1;
            end
          end
          ev[ev_count] = mk_event(dctp_pkg::EV_WRITE, preg, wv, 1'b0, rel_next, line_cnt,
                                  pos_cnt, 16'd0, 16'd0, dctp_pkg::ERR_NONE);
          ev_count = ev_count + 2'd1;
          has_writes_next = 1'b1;
        end else if (mode == MODE_STRING) begin
          ev[ev_count] = mk_event(dctp_pkg::EV_STRING, 4'd0, VB'(0), 1'b0, rel_next,
                                  line_cnt, pos_cnt, str_begin, str_count,
                                  dctp_pkg::ERR_NONE);
          ev_count = ev_count + 2'd1;
        end
        if (has_writes_next) begin
          ev[ev_count] = mk_event(dctp_pkg::EV_EXECUTE, 4'd0, opc_next,
                                  dctp_pkg::code_known(opc_next), rel_next, line_cnt,
                                  pos_cnt, 16'd0, 16'd0, dctp_pkg::ERR_NONE);
          ev_count = ev_count + 2'd1;
        end
      end
      ev[ev_count] = mk_event(dctp_pkg::EV_DONE, 4'd0, VB'(0), 1'b0, rel_next, line_cnt,
                              pos_cnt, 16'd0, 16'd0, err);
      ev_count = ev_count + 2'd1;
      // Page finished: back to reset state
      mode_next       = MODE_EXPECT;
      preg_next       = 4'd0;
      pupper_next     = 1'b0;
      neg_next        = 1'b0;
      acc_next        = '0;
      opc_next        = '0;
      rel_next        = 1'b0;
      has_writes_next = 1'b0;
      line_cnt_next   = 16'd0;
      pos_cnt_next    = 16'd0;
      byte_off_next   = 16'd0;
      str_begin_next  = 16'd0;
      str_count_next  = 16'd0;
      err_next        = dctp_pkg::ERR_NONE;
    end else if (err == dctp_pkg::ERR_NONE) begin
      unique case (mode)
        MODE_STRING: begin
          if (head_token.cls == dctp_pkg::TOK_NEWLINE) begin
            ev[ev_count] = mk_event(dctp_pkg::EV_STRING, 4'd0, VB'(0), 1'b0, rel,
                                    line_cnt, pos_cnt, str_begin, str_count,
                                    dctp_pkg::ERR_NONE);
            ev_count = ev_count + 2'd1;
            mode_next = MODE_EXPECT;
            nl_go = 1'b1;
          end else begin
            str_count_next = dctp_pkg::sat_inc(str_count);
          end
        end
        MODE_VALUE, MODE_DIGITS: begin
          if (mode == MODE_VALUE && head_token.cls == dctp_pkg::TOK_MINUS) begin
            neg_next = 1'b1;
            pos_cnt_next = dctp_pkg::sat_inc(pos_cnt);
            mode_next = MODE_DIGITS;
          end else if (head_token.cls == dctp_pkg::TOK_DIGIT) begin
            acc_next = (acc << 3) + (acc << 1) + VB'(head_token.digit);
            pos_cnt_next = dctp_pkg::sat_inc(pos_cnt);
            mode_next = MODE_DIGITS;
          end else begin
            // Any other byte closes the pending write and starts a new token
            if (preg == dctp_pkg::RegG) begin
              opc_next = wv;
              if (pupper && wv == dctp_pkg::GAbsolute) begin
                rel_next = 1'b0;
              end else if (pupper && wv == dctp_pkg::GRelative) begin
                rel_next = 1'b1;
              end
            end
            ev[ev_count] = mk_event(dctp_pkg::EV_WRITE, preg, wv, 1'b0, rel_next, line_cnt,
                                    pos_cnt, 16'd0, 16'd0, dctp_pkg::ERR_NONE);
            ev_count = ev_count + 2'd1;
            has_writes_next = 1'b1;
            mode_next = MODE_EXPECT;
            tok_go = 1'b1;
          end
        end
        default: begin
          tok_go = 1'b1;
        end
      endcase

      // New token
      if (tok_go) begin
        unique case (head_token.cls)
          dctp_pkg::TOK_SKIP: begin
          end
          dctp_pkg::TOK_QUOTE: begin
            mode_next = MODE_STRING;
            str_begin_next = dctp_pkg::sat_inc(byte_off);
            str_count_next = 16'd0;
          end
          dctp_pkg::TOK_NEWLINE: begin
            nl_go = 1'b1;
          end
          dctp_pkg::TOK_LETTER: begin
            pos_cnt_next = dctp_pkg::sat_inc(pos_cnt);
            preg_next = head_token.reg_index;
            pupper_next = head_token.upper;
            neg_next = 1'b0;
            acc_next = '0;
            mode_next = MODE_VALUE;
          end
          dctp_pkg::TOK_BAD_LETTER: begin
            pos_cnt_next = dctp_pkg::sat_inc(pos_cnt);
            err_next = dctp_pkg::ERR_BAD_REG;
            ev[ev_count] = mk_event(dctp_pkg::EV_ERROR, 4'd0, VB'(0), 1'b0, rel_next,
                                    line_cnt, pos_cnt_next, 16'd0, 16'd0,
                                    dctp_pkg::ERR_BAD_REG);
            ev_count = ev_count + 2'd1;
          end
          default: begin
            pos_cnt_next = dctp_pkg::sat_inc(pos_cnt);
            err_next = dctp_pkg::ERR_EXPECT_REG;
            ev[ev_count] = mk_event(dctp_pkg::EV_ERROR, 4'd0, VB'(0), 1'b0, rel_next,
                                    line_cnt, pos_cnt_next, 16'd0, 16'd0,
                                    dctp_pkg::ERR_EXPECT_REG);
            ev_count = ev_count + 2'd1;
          end
        endcase
      end

      // Newline: execute the line if it wrote anything
      if (nl_go) begin
        if (has_writes_next) begin
          ev[ev_count] = mk_event(dctp_pkg::EV_EXECUTE, 4'd0, opc_next,
                                  dctp_pkg::code_known(opc_next), rel_next, line_cnt,
                                  pos_cnt_next, 16'd0, 16'd0, dctp_pkg::ERR_NONE);
          ev_count = ev_count + 2'd1;
        end
        line_cnt_next = dctp_pkg::sat_inc(line_cnt);
        has_writes_next = 1'b0;
      end

      byte_off_next = dctp_pkg::sat_inc(byte_off);
    end
  end

  // Hand out events one per cycle while the receiver does not stall; retire the token after its last event
  assign out_ready = !event_valid || !event_stall;
  assign last_ev   = (idx == ev_count - 2'd1);
  assign pop       = head_valid && ((ev_count == 2'd0) || (out_ready && last_ev));

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_EXPECT;
      preg        <= 4'd0;
      pupper      <= 1'b0;
      neg         <= 1'b0;
      acc         <= '0;
      opc         <= '0;
      rel         <= 1'b0;
      has_writes  <= 1'b0;
      line_cnt    <= 16'd0;
      pos_cnt     <= 16'd0;
      byte_off    <= 16'd0;
      str_begin   <= 16'd0;
      str_count   <= 16'd0;
      err         <= dctp_pkg::ERR_NONE;
      idx         <= 2'd0;
      event_valid <= 1'b0;
    end else begin
      if (pop) begin
        mode       <= mode_next;
        preg       <= preg_next;
        pupper     <= pupper_next;
        neg        <= neg_next;
        acc        <= acc_next;
        opc        <= opc_next;
        rel        <= rel_next;
        has_writes <= has_writes_next;
        line_cnt   <= line_cnt_next;
        pos_cnt    <= pos_cnt_next;
        byte_off   <= byte_off_next;
        str_begin  <= str_begin_next;
        str_count  <= str_count_next;
        err        <= err_next;
      end
      if (head_valid && ev_count != 2'd0 && out_ready) begin
        event_valid <= 1'b1;
        event_data  <= ev[idx];
        event_last  <= last_ev;
        idx         <= last_ev ? 2'd0 : idx + 2'd1;
      end else if (!event_stall) begin
        event_valid <= 1'b0;
      end
    end
  end

endmodule
